>>> sv/skrt_pkg.sv
// Shared types and constants for the sorted key record table.
// Used by the table memory, the sequencer and the top level.
package skrt_pkg;

  localparam int KeyHighW = 64;
  localparam int KeyLowW  = 48;
  localparam int ScoreW   = 8;
  localparam int SumW     = 10;

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_LOOKUP = 2'd1,
    CMD_UPDATE = 2'd2,
    CMD_DELETE = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_FULL      = 3'd1,
    ST_DUPLICATE = 3'd2,
    ST_EMPTY     = 3'd3,
    ST_NOT_FOUND = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SEARCH,
    S_SHIFT,
    S_WRITE,
    S_OUT
  } state_t;

  // Register index, taken from paddr[2].
  localparam logic REG_PASS_SUM = 1'b0;

  typedef struct packed {
    logic [KeyHighW-1:0] key_high;
    logic [KeyLowW-1:0]  key_low;
    logic [ScoreW-1:0]   s1;
    logic [ScoreW-1:0]   s2;
    logic [ScoreW-1:0]   s3;
  } rec_t;

endpackage

>>> sv/sorted_key_record_table.sv
// Sorted key record table. Commands arrive on the s_axis channel, one result
// item leaves on m_axis for every command; pass_sum is set over APB.
// Payload s_axis_tdata (low bit first): key_high[63:0], key_low[111:64],
// score_one, score_two, score_three, update_mask[138:136], zero fill to 144
// bits; s_axis_tuser carries cmd. m_axis_tdata (low bit first): status[2:0],
// position[6:3], entry_total[11:7], out_score_one, out_score_two,
// out_score_three, score_sum[45:36], passed[46], zero fill to 48 bits.
// One command is worked on at a time. The key search reads the record
// memory one entry a cycle (the read data is registered), and insert and
// delete then move one entry a cycle. The next command can be taken in
// the cycle after the result is loaded.
// Reset empties the table (entry count zero) and sets pass_sum to 225; the
// memory contents are not cleared, as the read data of entries at or above
// the count is never used. A stalled receiver holds one result in the output
// register; the next result waits inside and s_axis_tready stays low until it moves.
module sorted_key_record_table #(
  parameter int DEPTH = 16
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [143:0] s_axis_tdata,   // key_high, key_low, scores 1-3, update_mask
  input  logic [1:0]   s_axis_tuser,   // cmd
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [47:0]  m_axis_tdata,   // status, position, entry_total, scores, sum, passed
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [2:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  skrt_pkg::state_t state, state_next;

  logic [skrt_pkg::SumW-1:0] pass_sum;
  skrt_pkg::cmd_t cmd;
  skrt_pkg::rec_t req;
  logic [2:0] mask;
  logic [CW-1:0] count;
  logic [CW-1:0] idx;
  logic [AW-1:0] pos;
  logic [CW-1:0] mv;
  logic [CW-1:0] left;
  logic rd_pending;
  logic [47:0] res;
  logic [47:0] out_data;
  logic out_valid;
  logic out_load;
  logic shift_rd;
  logic dir_up;
  logic [AW-1:0] shift_dst;

  logic mem_we;
  logic [AW-1:0] mem_waddr, mem_raddr;
  skrt_pkg::rec_t mem_wdata, mem_rdata;

  skrt_mem #(.DEPTH(DEPTH), .AW(AW)) u_mem (
    .clk(clk), .we(mem_we), .waddr(mem_waddr), .wdata(mem_wdata),
    .raddr(mem_raddr), .rdata(mem_rdata)
  );

  assign pready = 1'b1;
  assign prdata = (paddr[2] == skrt_pkg::REG_PASS_SUM) ? {22'd0, pass_sum} : 32'd0;
  assign s_axis_tready = (state == skrt_pkg::S_IDLE);
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata = out_data;
  assign out_load = (state == skrt_pkg::S_OUT) && (!out_valid || m_axis_tready);

  always_ff @(posedge clk) begin
    if (rst) begin
      pass_sum <= 10'd225;
    end else if (psel && penable && pwrite && paddr[2] == skrt_pkg::REG_PASS_SUM) begin
      pass_sum <= pwdata[9:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= skrt_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Key compare of the entry just read against the request key.
  logic key_ge, key_eq;
  always_comb begin
    key_eq = (mem_rdata.key_high == req.key_high) && (mem_rdata.key_low == req.key_low);
    key_ge = (mem_rdata.key_high > req.key_high) ||
             ((mem_rdata.key_high == req.key_high) && (mem_rdata.key_low >= req.key_low));
  end

  // Outcome of the search in the current cycle. The rank is the first entry
  // whose key is not below the request key, or the count when there is none.
  logic early, done, hit;
  logic [CW-1:0] rank;
  skrt_pkg::rec_t merged;
  always_comb begin
    early = (cmd == skrt_pkg::CMD_INSERT) ? (count == CW'(DEPTH)) : (count == '0);
    done = 1'b0;
    hit = 1'b0;
    rank = count;
    if (rd_pending && key_ge) begin
      done = 1'b1;
      hit = key_eq;
      rank = idx - CW'(1);
    end else if (idx == count) begin
      done = 1'b1;
    end
    merged = mem_rdata;
    if (mask[0]) begin
      merged.s1 = req.s1;
    end
    if (mask[1]) begin
      merged.s2 = req.s2;
    end
    if (mask[2]) begin
      merged.s3 = req.s3;
    end
  end

  function automatic logic [47:0] pack_out(input skrt_pkg::status_t st, input logic touched,
                                          input logic [AW-1:0] p, input logic [CW-1:0] n,
                                          input skrt_pkg::rec_t r,
                                          input logic [skrt_pkg::SumW-1:0] thr);
    logic [skrt_pkg::SumW-1:0] sum;
    logic [3:0] p4;
    logic [4:0] n5;
    logic [CW+4:0] nw;
    logic [AW+3:0] pw;
    sum = {2'b00, r.s1} + {2'b00, r.s2} + {2'b00, r.s3};
    pw = {4'd0, p};
    nw = {5'd0, n};
    p4 = pw[3:0];
    n5 = nw[4:0];
    if (touched) begin
      pack_out = {1'b0, (sum >= thr), sum, r.s3, r.s2, r.s1, n5, p4, st};
    end else begin
      pack_out = {1'b0, 1'b0, 10'd0, 24'd0, n5, 4'd0, st};
    end
  endfunction

  // Sequencer: search, shift and write where needed, then hand the result over.
  always_comb begin
    state_next = state;
    mem_we = 1'b0;
    mem_waddr = pos;
    mem_wdata = req;
    mem_raddr = idx[AW-1:0];
    case (state)
      skrt_pkg::S_IDLE: begin
        if (s_axis_tvalid) begin
          state_next = skrt_pkg::S_SEARCH;
        end
      end
      skrt_pkg::S_SEARCH: begin
        if (early) begin
          state_next = skrt_pkg::S_OUT;
        end else if (done) begin
          if ((cmd == skrt_pkg::CMD_INSERT && !hit) ||
              (cmd == skrt_pkg::CMD_DELETE && hit)) begin
            state_next = skrt_pkg::S_SHIFT;
          end else begin
            state_next = skrt_pkg::S_OUT;
          end
          // The write port is idle here, so an update is written back at once.
          if (cmd == skrt_pkg::CMD_UPDATE && hit) begin
            mem_we = 1'b1;
            mem_waddr = rank[AW-1:0];
            mem_wdata = merged;
          end
        end
      end
      skrt_pkg::S_SHIFT: begin
        // Read mv, write it to its neighbor the next cycle.
        mem_raddr = mv[AW-1:0];
        mem_we = shift_rd;
        mem_waddr = shift_dst;
        mem_wdata = mem_rdata;
        if (left == '0) begin
          state_next = (cmd == skrt_pkg::CMD_INSERT) ? skrt_pkg::S_WRITE : skrt_pkg::S_OUT;
        end
      end
      skrt_pkg::S_WRITE: begin
        mem_we = 1'b1;
        state_next = skrt_pkg::S_OUT;
      end
      skrt_pkg::S_OUT: begin
        if (out_load) begin
          state_next = skrt_pkg::S_IDLE;
        end
      end
      default: state_next = skrt_pkg::S_IDLE;
    endcase
  end

  // Datapath and the handshake of the output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      count <= '0;
      rd_pending <= 1'b0;
      shift_rd <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
        out_data <= res;
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
      case (state)
        skrt_pkg::S_IDLE: begin
          if (s_axis_tvalid) begin
            cmd <= skrt_pkg::cmd_t'(s_axis_tuser);
            req.key_high <= s_axis_tdata[63:0];
            req.key_low <= s_axis_tdata[111:64];
            req.s1 <= s_axis_tdata[119:112];
            req.s2 <= s_axis_tdata[127:120];
            req.s3 <= s_axis_tdata[135:128];
            mask <= s_axis_tdata[138:136];
            idx <= '0;
            rd_pending <= 1'b0;
          end
        end
        skrt_pkg::S_SEARCH: begin
          if (early) begin
            rd_pending <= 1'b0;
            res <= pack_out((cmd == skrt_pkg::CMD_INSERT) ? skrt_pkg::ST_FULL :
                            skrt_pkg::ST_EMPTY, 1'b0, '0, count, req, pass_sum);
          end else if (done) begin
            rd_pending <= 1'b0;
            shift_rd <= 1'b0;
            pos <= rank[AW-1:0];
            case (cmd)
              skrt_pkg::CMD_INSERT: begin
                if (hit) begin
                  res <= pack_out(skrt_pkg::ST_DUPLICATE, 1'b1, rank[AW-1:0], count,
                                  mem_rdata, pass_sum);
                end else begin
                  res <= pack_out(skrt_pkg::ST_OK, 1'b1, rank[AW-1:0], count + CW'(1),
                                  req, pass_sum);
                  count <= count + CW'(1);
                  mv <= count - CW'(1);
                  left <= count - rank;
                  dir_up <= 1'b1;
                end
              end
              skrt_pkg::CMD_LOOKUP: begin
                res <= pack_out(hit ? skrt_pkg::ST_OK : skrt_pkg::ST_NOT_FOUND, hit,
                                rank[AW-1:0], count, mem_rdata, pass_sum);
              end
              skrt_pkg::CMD_UPDATE: begin
                res <= pack_out(hit ? skrt_pkg::ST_OK : skrt_pkg::ST_NOT_FOUND, hit,
                                rank[AW-1:0], count, merged, pass_sum);
              end
              skrt_pkg::CMD_DELETE: begin
                if (hit) begin
                  res <= pack_out(skrt_pkg::ST_OK, 1'b1, rank[AW-1:0], count - CW'(1),
                                  mem_rdata, pass_sum);
                  count <= count - CW'(1);
                  mv <= rank + CW'(1);
                  left <= count - rank - CW'(1);
                  dir_up <= 1'b0;
                end else begin
                  res <= pack_out(skrt_pkg::ST_NOT_FOUND, 1'b0, '0, count, mem_rdata,
                                  pass_sum);
                end
              end
              default: ;
            endcase
          end else begin
            rd_pending <= 1'b1;
            idx <= idx + CW'(1);
          end
        end
        skrt_pkg::S_SHIFT: begin
          if (left != '0) begin
            shift_rd <= 1'b1;
            shift_dst <= dir_up ? mv[AW-1:0] + AW'(1) : mv[AW-1:0] - AW'(1);
            mv <= dir_up ? mv - CW'(1) : mv + CW'(1);
            left <= left - CW'(1);
          end else begin
            shift_rd <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

endmodule

>>> sv/skrt_mem.sv
// Record memory of the sorted key record table: one write port and one
// read port with registered read data. Depends on skrt_pkg.
module skrt_mem #(
  parameter int DEPTH = 16,
  parameter int AW = 4
) (
  input  logic           clk,
  input  logic           we,
  input  logic [AW-1:0]  waddr,
  input  skrt_pkg::rec_t wdata,
  input  logic [AW-1:0]  raddr,
  output skrt_pkg::rec_t rdata
);

  skrt_pkg::rec_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
